// File: rtl/sacd_pkg.sv
// shared types and constants of the set-associative cache tag directory
// no dependencies; used by the interfaces, controller, datapath and top level
`default_nettype none

package sacd_pkg;

	localparam int unsigned SETS_DEF   = 64;
	localparam int unsigned WAYS_DEF   = 8;
	localparam int          TAG_W      = 32;
	localparam int          STAMP_W    = 48;
	localparam int          LEN_W      = 16;
	localparam int          CFG_IDX_W  = 2;
	localparam int          CFG_DATA_W = 16;

	localparam logic              RD_EN_RST   = 1'b1;
	localparam logic              WR_EN_RST   = 1'b1;
	localparam logic              POLICY_RST  = 1'b1;
	localparam logic [LEN_W-1:0]  LINE_SZ_RST = 16'd4096;

	// request opcodes
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_INVAL = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_READ_EN   = 2'd0,
		CFG_WRITE_EN  = 2'd1,
		CFG_POLICY    = 2'd2,
		CFG_LINE_SIZE = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [TAG_W-1:0]   line_address;
		logic [LEN_W-1:0]   request_length;
		logic [STAMP_W-1:0] now;
	} req_t;

	typedef struct packed {
		logic             hit;
		logic             served;
		logic [2:0]       way_used;
		logic             fill_needed;
		logic             writeback_valid;
		logic [TAG_W-1:0] writeback_address;
	} rsp_t;

	// one way of a set
	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic               valid;
		logic               dirty;
		logic [STAMP_W-1:0] ins;
		logic [STAMP_W-1:0] acc;
	} way_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic quo;
		logic rem;
		logic rd;
		logic look;
		logic commit;
		logic clr;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic clr_last;
	} stat_t;

endpackage

`default_nettype wire

// File: rtl/sacd_req_if.sv
// request channel of the cache directory
// depends on sacd_pkg
`default_nettype none

interface sacd_req_if;
	import sacd_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/sacd_rsp_if.sv
// result channel of the cache directory
// depends on sacd_pkg
`default_nettype none

interface sacd_rsp_if;
	import sacd_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/sacd_ctrl.sv
// sequencer of the cache directory: set clearing after reset, then one request at a time
// depends on sacd_pkg
`default_nettype none

module sacd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  sacd_pkg::stat_t stat,
	output sacd_pkg::cmd_t  cmd
);
	import sacd_pkg::*;

	typedef enum logic [6:0] {
		S_CLR  = 7'b0000001,
		S_IDLE = 7'b0000010,
		S_QUO  = 7'b0000100,
		S_REM  = 7'b0001000,
		S_RD   = 7'b0010000,
		S_LOOK = 7'b0100000,
		S_WR   = 7'b1000000
	} state_t;

	state_t state_q, state_n;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_CLR:  if (stat.clr_last) state_n = S_IDLE;
			S_IDLE: if (req_valid) state_n = S_QUO;
			S_QUO:  state_n = S_REM;
			S_REM:  state_n = S_RD;
			S_RD:   state_n = S_LOOK;
			S_LOOK: state_n = S_WR;
			S_WR:   if (stat.out_free) state_n = S_IDLE;
			default: state_n = S_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_n;
		end
	end

	assign req_ready  = (state_q == S_IDLE);
	assign cmd.accept = (state_q == S_IDLE) && req_valid;
	assign cmd.quo    = (state_q == S_QUO);
	assign cmd.rem    = (state_q == S_REM);
	assign cmd.rd     = (state_q == S_RD);
	assign cmd.look   = (state_q == S_LOOK);
	assign cmd.commit = (state_q == S_WR) && stat.out_free;
	assign cmd.clr    = (state_q == S_CLR);

endmodule

`default_nettype wire

// File: rtl/sacd_dp.sv
// datapath of the cache directory: set index unit, set memory, way search, update, result register
// depends on sacd_pkg
`default_nettype none

module sacd_dp #(
	parameter int unsigned SETS = sacd_pkg::SETS_DEF,
	parameter int unsigned WAYS = sacd_pkg::WAYS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sacd_pkg::cmd_t                 cmd,
	output sacd_pkg::stat_t                stat,
	input  sacd_pkg::req_t                 req_data,
	input  logic                           cfg_we,
	input  logic [sacd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [sacd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output sacd_pkg::rsp_t                 rsp_data
);
	import sacd_pkg::*;

	localparam int SB    = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WB    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WP    = 1 << WB;
	localparam int DL    = $clog2(SETS);
	localparam int SH    = TAG_W + DL;
	localparam int PW    = SH + TAG_W;
	localparam int RW    = DL + 2;
	localparam int KW    = STAMP_W + 1;
	localparam logic [TAG_W:0] RECIP = (TAG_W + 1)'((64'd1 << SH) / SETS);

	typedef way_t [WAYS-1:0] row_t;

	// configuration
	logic               rd_en_q, wr_en_q, policy_q;
	logic [LEN_W-1:0]   line_sz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_en_q   <= RD_EN_RST;
			wr_en_q   <= WR_EN_RST;
			policy_q  <= POLICY_RST;
			line_sz_q <= LINE_SZ_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_READ_EN:   rd_en_q   <= cfg_wdata[0];
				CFG_WRITE_EN:  wr_en_q   <= cfg_wdata[0];
				CFG_POLICY:    policy_q  <= cfg_wdata[0];
				CFG_LINE_SIZE: line_sz_q <= cfg_wdata;
			endcase
		end
	end

	// request capture and set index by reciprocal multiply
	req_t             req_q;
	logic [TAG_W-1:0] quo_q;
	logic [SB-1:0]    set_q;
	logic [PW-1:0]    prod;
	logic [TAG_W-1:0] qd;
	logic [TAG_W-1:0] rfull;
	logic [RW-1:0]    rlow;

	assign prod  = PW'(req_q.line_address) * PW'(RECIP);
	assign qd    = TAG_W'(quo_q * TAG_W'(SETS));
	assign rfull = req_q.line_address - qd;
	assign rlow  = rfull[RW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.accept) req_q <= req_data;
		if (cmd.quo) quo_q <= prod[SH +: TAG_W];
		if (cmd.rem) begin
			if (rlow >= RW'(SETS)) set_q <= SB'(rlow - RW'(SETS));
			else set_q <= SB'(rlow);
		end
	end

	// clearing pass after reset
	logic [SB-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + SB'(1);
		end
	end

	assign stat.clr_last = (clr_q == SB'(SETS - 1));

	// set memory, one row per set
	row_t          mem [SETS];
	row_t          rd_q;
	row_t          new_row;
	logic          mem_we;
	logic [SB-1:0] mem_wa;
	row_t          mem_wd;

	assign mem_we = cmd.clr | cmd.commit;
	assign mem_wa = cmd.clr ? clr_q : set_q;
	assign mem_wd = cmd.clr ? '0 : new_row;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (cmd.rd) rd_q <= mem[set_q];
	end

	// way search: hit, least-stamped free way, victim by policy
	logic [KW-1:0] fk [WP];
	logic [KW-1:0] vk [WP];
	logic [WB-1:0] fi [WP];
	logic [WB-1:0] vi [WP];
	logic          hit_n;
	logic [WB-1:0] hw_n;

	always_comb begin
		hit_n = 1'b0;
		hw_n  = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (rd_q[w].valid && rd_q[w].tag == req_q.line_address) begin
				hit_n = 1'b1;
				hw_n  = WB'(w);
			end
		end
		for (int i = 0; i < WP; i++) begin
			fi[i] = WB'(i);
			vi[i] = WB'(i);
			if (i < WAYS) begin
				fk[i] = {rd_q[i].valid, rd_q[i].ins};
				vk[i] = {1'b0, policy_q ? rd_q[i].acc : rd_q[i].ins};
			end else begin
				fk[i] = '1;
				vk[i] = '1;
			end
		end
		// tournament, left side wins ties
		for (int s = 1; s < WP; s = s * 2) begin
			for (int i = 0; i + s < WP; i = i + 2 * s) begin
				if (fk[i+s] < fk[i]) begin
					fk[i] = fk[i+s];
					fi[i] = fi[i+s];
				end
				if (vk[i+s] < vk[i]) begin
					vk[i] = vk[i+s];
					vi[i] = vi[i+s];
				end
			end
		end
	end

	logic          hit_q, evict_q;
	logic [WB-1:0] way_q;

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			hit_q   <= hit_n;
			evict_q <= !hit_n && fk[0][KW-1];
			if (hit_n) way_q <= hw_n;
			else if (!fk[0][KW-1]) way_q <= fi[0];
			else way_q <= vi[0];
		end
	end

	// update of the selected way and the result
	way_t               e, ne;
	rsp_t               rsp_n;
	logic               dirty_n;
	logic [STAMP_W-1:0] base_ins, t_new;

	always_comb begin
		e        = rd_q[way_q];
		ne       = e;
		new_row  = rd_q;
		rsp_n    = '0;
		dirty_n  = req_q.request_length < line_sz_q;
		base_ins = evict_q ? '0 : e.ins;
		t_new    = (dirty_n && base_ins > req_q.now) ? base_ins : req_q.now;
		priority if (req_q.opcode == OP_READ && rd_en_q) begin
			rsp_n.way_used = 3'(way_q);
			if (hit_q) begin
				ne.acc       = (req_q.now > e.ins) ? req_q.now : e.ins;
				rsp_n.hit    = 1'b1;
				rsp_n.served = 1'b1;
			end else begin
				ne.tag               = req_q.line_address;
				ne.valid             = 1'b1;
				ne.dirty             = 1'b0;
				ne.ins               = req_q.now;
				ne.acc               = req_q.now;
				rsp_n.fill_needed    = 1'b1;
				rsp_n.writeback_valid = evict_q && e.dirty;
				if (evict_q && e.dirty) rsp_n.writeback_address = e.tag;
			end
		end else if (req_q.opcode == OP_WRITE && wr_en_q) begin
			ne.tag                = req_q.line_address;
			ne.valid              = 1'b1;
			ne.dirty              = dirty_n;
			ne.ins                = t_new;
			ne.acc                = t_new;
			rsp_n.hit             = hit_q;
			rsp_n.served          = 1'b1;
			rsp_n.way_used        = 3'(way_q);
			rsp_n.writeback_valid = evict_q && e.dirty;
			if (evict_q && e.dirty) rsp_n.writeback_address = e.tag;
		end else if (req_q.opcode == OP_INVAL && (rd_en_q || wr_en_q)) begin
			rsp_n.served = 1'b1;
			if (hit_q) begin
				ne.valid       = 1'b0;
				ne.dirty       = 1'b0;
				rsp_n.hit      = 1'b1;
				rsp_n.way_used = 3'(way_q);
			end
		end else begin
			ne = e;
		end
		new_row[way_q] = ne;
	end

	// result register
	logic out_v_q;
	rsp_t out_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.commit) begin
			out_v_q <= 1'b1;
		end else if (rsp_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) out_d_q <= rsp_n;
	end

	assign rsp_valid     = out_v_q;
	assign rsp_data      = out_d_q;
	assign stat.out_free = !out_v_q || rsp_ready;

endmodule

`default_nettype wire

// File: rtl/set_assoc_cache_directory_unit.sv
// top level of the set-associative cache tag directory
// depends on sacd_pkg, sacd_req_if, sacd_rsp_if, sacd_ctrl, sacd_dp
//
//  port    | dir | kind           | carries
//  --------+-----+----------------+-------------------------------------------
//  req     | in  | valid/ready    | opcode, line_address, request_length, now
//  rsp     | out | valid/ready    | hit, served, way_used, fill_needed, writeback
//  cfg_*   | in  | write enable   | register index and data, no read-back
//
// one request goes from acceptance to the next acceptance through capture,
// quotient multiply, remainder, set read, way search and set update; the set memory's
// single read and write port and the reciprocal set index unit give these steps.
// after reset a clearing pass writes every set once before the first
// request is taken; configuration writes are taken at any time.
// a finished result waits in the output register; the next request is accepted
// meanwhile and only its update stage waits for the register to free up.
`default_nettype none

module set_assoc_cache_directory_unit #(
	parameter int unsigned SETS = sacd_pkg::SETS_DEF,
	parameter int unsigned WAYS = sacd_pkg::WAYS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	sacd_req_if.sink                        req,
	sacd_rsp_if.source                      rsp,
	input  logic                            cfg_we,
	input  logic [sacd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [sacd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import sacd_pkg::*;

	// command and status between sequencer and datapath
	cmd_t  cmd;
	stat_t stat;

	// sequencer: clearing pass, then one request walks through the stages
	sacd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: set index, set memory, way search, update and result register
	sacd_dp #(
		.SETS (SETS),
		.WAYS (WAYS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_data  (req.data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_data  (rsp.data)
	);

endmodule

`default_nettype wire

// File: tb/tb.sv
// self-checking testbench of the set-associative cache tag directory
// depends on sacd_pkg, sacd_req_if, sacd_rsp_if and set_assoc_cache_directory_unit
// drives requests and config writes, checks every result against its own directory model or a typed row's expectation
`default_nettype none

module tb;
	import sacd_pkg::*;

	localparam int          N_SETS    = 64;
	localparam int          N_WAYS    = 8;
	localparam int          N_LINES   = N_SETS * N_WAYS;
	localparam logic [1:0]  OP_UNUSED = 2'd3;
	localparam int          MAX_CYC   = 600000;
	localparam int          N_PHASES  = 8;
	localparam int          PER_PHASE = 175;

	typedef struct {
		req_t rq;
		bit   typed;
		rsp_t rs;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	sacd_req_if req_ch ();
	sacd_rsp_if rsp_ch ();

	set_assoc_cache_directory_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// model copy of the directory
	logic [TAG_W-1:0]   m_tag   [N_LINES];
	logic               m_valid [N_LINES];
	logic               m_dirty [N_LINES];
	logic [STAMP_W-1:0] m_ins   [N_LINES];
	logic [STAMP_W-1:0] m_acc   [N_LINES];
	logic               m_rd_en, m_wr_en, m_lru;
	logic [LEN_W-1:0]   m_line_sz;

	rsp_t   pending_rsp[$];
	int     idle_mode;
	int     n_bad = 0;
	int     cyc = 0;
	logic [STAMP_W-1:0] clock_now;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > MAX_CYC) begin
			$display("tb: errors");
			$finish;
		end
	end

	// way lookups within one set; N_WAYS means none
	function automatic int hit_way(int base, logic [TAG_W-1:0] a);
		for (int w = 0; w < N_WAYS; w++)
			if (m_valid[base+w] && m_tag[base+w] == a) return w;
		return N_WAYS;
	endfunction

	// invalid way with the oldest insert stamp, first on ties
	function automatic int free_way(int base);
		int best;
		best = N_WAYS;
		for (int w = 0; w < N_WAYS; w++)
			if (!m_valid[base+w] && (best == N_WAYS || m_ins[base+w] < m_ins[base+best]))
				best = w;
		return best;
	endfunction

	// fifo or lru victim, first on ties
	function automatic int victim_way(int base);
		int best;
		best = 0;
		for (int w = 1; w < N_WAYS; w++)
			if (m_lru ? (m_acc[base+w] < m_acc[base+best]) : (m_ins[base+w] < m_ins[base+best]))
				best = w;
		return best;
	endfunction

	// directory update for one accepted request, returns its result
	function automatic rsp_t lookup_update(req_t r);
		rsp_t               o;
		int                 base, w, i;
		logic               dty;
		logic [STAMP_W-1:0] t;
		o    = '0;
		base = int'(r.line_address % N_SETS) * N_WAYS;
		if (r.opcode == OP_READ && m_rd_en) begin
			w = hit_way(base, r.line_address);
			if (w < N_WAYS) begin
				i = base + w;
				m_acc[i] = (r.now > m_ins[i]) ? r.now : m_ins[i];
				o.hit    = 1'b1;
				o.served = 1'b1;
			end else begin
				w = free_way(base);
				if (w == N_WAYS) begin
					w = victim_way(base);
					if (m_dirty[base+w]) begin
						o.writeback_valid   = 1'b1;
						o.writeback_address = m_tag[base+w];
					end
				end
				i = base + w;
				m_tag[i]   = r.line_address;
				m_valid[i] = 1'b1;
				m_dirty[i] = 1'b0;
				m_ins[i]   = r.now;
				m_acc[i]   = r.now;
				o.fill_needed = 1'b1;
			end
			o.way_used = w[2:0];
		end else if (r.opcode == OP_WRITE && m_wr_en) begin
			// short write leaves the line dirty; zero line size never counts as short
			dty = r.request_length < m_line_sz;
			w   = hit_way(base, r.line_address);
			if (w < N_WAYS) begin
				o.hit = 1'b1;
			end else begin
				w = free_way(base);
				if (w == N_WAYS) begin
					w = victim_way(base);
					if (m_dirty[base+w]) begin
						o.writeback_valid   = 1'b1;
						o.writeback_address = m_tag[base+w];
					end
					m_ins[base+w] = '0;
				end
			end
			i = base + w;
			t = (dty && m_ins[i] > r.now) ? m_ins[i] : r.now;
			m_ins[i]   = t;
			m_acc[i]   = t;
			m_tag[i]   = r.line_address;
			m_valid[i] = 1'b1;
			m_dirty[i] = dty;
			o.served   = 1'b1;
			o.way_used = w[2:0];
		end else if (r.opcode == OP_INVAL && (m_rd_en || m_wr_en)) begin
			// dirty data of an invalidated line are dropped
			o.served = 1'b1;
			w = hit_way(base, r.line_address);
			if (w < N_WAYS) begin
				m_valid[base+w] = 1'b0;
				m_dirty[base+w] = 1'b0;
				o.hit      = 1'b1;
				o.way_used = w[2:0];
			end
		end
		return o;
	endfunction

	// result side: random stalls, compare with the oldest expectation
	always @(posedge clk) begin
		rsp_t e;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				n_bad <= n_bad + 1;
				if (n_bad < 10) $display("unexpected result %h", rsp_ch.data);
			end else begin
				e = pending_rsp.pop_front();
				if (rsp_ch.data.hit !== e.hit || rsp_ch.data.served !== e.served
					|| rsp_ch.data.way_used !== e.way_used
					|| rsp_ch.data.fill_needed !== e.fill_needed
					|| rsp_ch.data.writeback_valid !== e.writeback_valid
					|| rsp_ch.data.writeback_address !== e.writeback_address) begin
					n_bad <= n_bad + 1;
					if (n_bad < 10)
						$display("mismatch exp %h got %h", e, rsp_ch.data);
				end
			end
		end
		case (idle_mode)
			2: rsp_ch.ready <= ($urandom_range(99) >= 61);
			3: rsp_ch.ready <= ($urandom_range(99) >= 37);
			default: rsp_ch.ready <= 1'b1;
		endcase
	end

	// one request through the handshake; typed rows carry their own expectation
	task automatic send_request(req_t r, bit typed, rsp_t rs);
		rsp_t p;
		int   gap_pct;
		gap_pct = (idle_mode == 1) ? 61 : (idle_mode == 3) ? 37 : 0;
		if ($urandom_range(99) < gap_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= r;
		do @(posedge clk); while (!req_ch.ready);
		p = lookup_update(r);
		pending_rsp.insert(pending_rsp.size(), typed ? rs : p);
	endtask

	// register write, idle block only
	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			CFG_READ_EN:  m_rd_en   = val[0];
			CFG_WRITE_EN: m_wr_en   = val[0];
			CFG_POLICY:   m_lru     = val[0];
			default:      m_line_sz = val;
		endcase
	endtask

	// mostly a few sets and a small tag pool so that hits and evictions are common
	function automatic req_t random_request();
		req_t r;
		int   k;
		k = $urandom_range(99);
		r.opcode = (k < 45) ? OP_READ : (k < 85) ? OP_WRITE : (k < 97) ? OP_INVAL : OP_UNUSED;
		if ($urandom_range(99) < 15)
			r.line_address = $urandom;
		else
			r.line_address = ($urandom_range(0, 11) << 6) | $urandom_range(0, 3);
		k = $urandom_range(99);
		if (k < 40)      r.request_length = LEN_W'($urandom);
		else if (k < 70) r.request_length = LEN_W'(m_line_sz + $urandom_range(0, 2) - 1);
		else if (k < 85) r.request_length = '0;
		else             r.request_length = 16'hFFFF;
		k = $urandom_range(99);
		if (k < 80) begin
			clock_now = clock_now + STAMP_W'($urandom_range(0, 3));
			r.now = clock_now;
		end else if (k < 90) begin
			r.now = STAMP_W'({$urandom, $urandom});
		end else begin
			r.now = STAMP_W'($urandom_range(0, 50));
		end
		return r;
	endfunction

	dir_row_t dir_tab [19];

	initial begin
		// settings per phase: read enable, write enable, lru, line size
		logic [CFG_DATA_W-1:0] ph_cfg [N_PHASES][4];
		rsp_t                  none;
		none = '0;
		ph_cfg = '{
			'{16'd1, 16'd1, 16'd0, 16'd4096},
			'{16'd0, 16'd1, 16'd1, 16'd100},
			'{16'd1, 16'd0, 16'd0, 16'd65535},
			'{16'd1, 16'd1, 16'd1, 16'd1},
			'{16'd0, 16'd0, 16'd1, 16'd512},
			'{16'd1, 16'd1, 16'd0, 16'd0},
			'{16'd1, 16'd1, 16'd1, 16'd65535},
			'{16'd1, 16'd1, 16'd0, 16'd2048}
		};

		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = '0;
		cfg_wdata    = '0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		idle_mode    = 0;
		clock_now    = 48'd1000;
		for (int i = 0; i < N_LINES; i++) begin
			m_tag[i]   = '0;
			m_valid[i] = 1'b0;
			m_dirty[i] = 1'b0;
			m_ins[i]   = '0;
			m_acc[i]   = '0;
		end
		m_rd_en   = RD_EN_RST;
		m_wr_en   = WR_EN_RST;
		m_lru     = POLICY_RST;
		m_line_sz = LINE_SZ_RST;

		// directed rows, reset settings: read, write and invalidate, extremes, eviction
		dir_tab[0] = '{'{OP_READ, 32'd0, 16'd0, 48'd10}, 1'b1, '{1'b0, 1'b0, 3'd0, 1'b1, 1'b0, 32'd0}};
		dir_tab[1] = '{'{OP_READ, 32'd0, 16'd0, 48'd20}, 1'b1, '{1'b1, 1'b1, 3'd0, 1'b0, 1'b0, 32'd0}};
		dir_tab[2] = '{'{OP_WRITE, 32'd64, 16'd0, 48'd30}, 1'b1, '{1'b0, 1'b1, 3'd1, 1'b0, 1'b0, 32'd0}};
		dir_tab[3] = '{'{OP_WRITE, 32'd64, 16'hFFFF, 48'd40}, 1'b1,
			'{1'b1, 1'b1, 3'd1, 1'b0, 1'b0, 32'd0}};
		dir_tab[4] = '{'{OP_INVAL, 32'd64, 16'd0, 48'd50}, 1'b1, '{1'b1, 1'b1, 3'd1, 1'b0, 1'b0, 32'd0}};
		dir_tab[5] = '{'{OP_INVAL, 32'd64, 16'd0, 48'd60}, 1'b1, '{1'b0, 1'b1, 3'd0, 1'b0, 1'b0, 32'd0}};
		dir_tab[6] = '{'{OP_UNUSED, 32'hFFFFFFFF, 16'hFFFF, 48'hFFFFFFFFFFFF}, 1'b1, none};
		dir_tab[7] = '{'{OP_READ, 32'hFFFFFFFF, 16'hFFFF, 48'hFFFFFFFFFFFF}, 1'b1,
			'{1'b0, 1'b0, 3'd0, 1'b1, 1'b0, 32'd0}};
		// fill set one with dirty lines, then force dirty evictions
		for (int k = 0; k < 8; k++)
			dir_tab[8+k] = '{'{OP_WRITE, 32'd1 + 32'd64 * k, 16'd0, 48'd100 + k}, 1'b0, none};
		dir_tab[16] = '{'{OP_READ, 32'd513, 16'd0, 48'd200}, 1'b0, none};
		dir_tab[17] = '{'{OP_WRITE, 32'd577, 16'd4095, 48'd5}, 1'b0, none};
		// write hit with a stamp older than the insert time
		dir_tab[18] = '{'{OP_WRITE, 32'd577, 16'd1, 48'd0}, 1'b0, none};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_request(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].rs);
		req_ch.valid <= 1'b0;

		for (int ph = 0; ph < N_PHASES; ph++) begin
			// drain, then let the pipeline settle before touching registers
			while (pending_rsp.size() != 0) @(posedge clk);
			repeat (12) @(posedge clk);
			write_reg(CFG_READ_EN, ph_cfg[ph][0]);
			write_reg(CFG_WRITE_EN, ph_cfg[ph][1]);
			write_reg(CFG_POLICY, ph_cfg[ph][2]);
			write_reg(CFG_LINE_SIZE, ph_cfg[ph][3]);
			cfg_we    <= 1'b0;
			idle_mode <= ph % 4;
			@(posedge clk);
			for (int n = 0; n < PER_PHASE; n++)
				send_request(random_request(), 1'b0, none);
			req_ch.valid <= 1'b0;
		end

		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (n_bad == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
rtl/sacd_pkg.sv
rtl/sacd_req_if.sv
rtl/sacd_rsp_if.sv
rtl/sacd_ctrl.sv
rtl/sacd_dp.sv
rtl/set_assoc_cache_directory_unit.sv
tb/tb.sv
